>>> design/kti_pkg.sv
// kti_pkg: shared types and codes for the keyframe track interpolator
// holds sizes, command codes, the keyframe record and the controller/datapath bundles
// no dependencies
`default_nettype none

package kti_pkg;

    // store sizes, tied to the 2-bit track and 3-bit slot fields
    localparam int MAX_FRAMES = 8;
    localparam int TRACKS     = 4;

    // track counter, frame counter and frame count widths
    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int IW = $clog2(MAX_FRAMES);
    localparam int NW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [1:0] {
        CMD_LOAD_KEY  = 2'd0,
        CMD_SET_COUNT = 2'd1,
        CMD_EVAL_SET  = 2'd2,
        CMD_EVAL_ADD  = 2'd3
    } cmd_code_t;

    // component order inside a keyframe record
    localparam logic [1:0] COMP_TIME  = 2'd0;
    localparam logic [1:0] COMP_X     = 2'd1;
    localparam logic [1:0] COMP_Y     = 2'd2;
    localparam logic [1:0] COMP_ANGLE = 2'd3;

    // time, x, y, angle
    typedef logic [3:0][31:0] frame_t;

    // controller to datapath
    typedef struct packed {
        logic wr_key;
        logic wr_count;
        logic latch_eval;
        logic rd_issue;
        logic shift_frame;
        logic clr_res;
        logic take_cur;
        logic div_init;
        logic div_step;
        logic div_first;
        logic lerp_mul;
        logic lerp_add;
        logic set_acc;
        logic add_mul;
        logic add_acc;
        logic out_load;
        logic out_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
    } dp_status_t;

endpackage

`default_nettype wire

>>> design/keyframe_track_interpolator_top.sv
// keyframe_track_interpolator_top: piecewise linear keyframe evaluator
// load/count items are taken only when idle and give no result
// per track: with no frames the result is cleared, else the keyframes are walked; divider
// and lerp on a hit, weighted add in add mode, then the output load
// the rate is set by the 17-step divider, the single shared multiplier and the keyframe walk
// reset (rst_n low, async) clears frame counts, accumulators and control; keyframes are not cleared
`default_nettype none

module keyframe_track_interpolator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [1:0]  track,
    input  wire logic [2:0]  frame_index,
    input  wire logic [3:0]  frame_count,
    input  wire logic [31:0] key_time,
    input  wire logic [31:0] key_x,
    input  wire logic [31:0] key_y,
    input  wire logic [31:0] key_angle,
    input  wire logic [31:0] eval_time,
    input  wire logic [23:0] amount,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       out_track,
    output logic [31:0]      out_time,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic [31:0]      out_angle,
    output logic             last
);

    // track counter, frame counter and frame count widths
    localparam int TW = kti_pkg::TW;
    localparam int IW = kti_pkg::IW;
    localparam int NW = kti_pkg::NW;

    kti_pkg::dp_cmd_t    dp_cmd;
    kti_pkg::dp_status_t dp_status;
    logic [NW-1:0]       frames;
    logic [TW-1:0]       trk;
    logic [IW-1:0]       idx;
    logic [1:0]          comp;

    // sequencer: accepts items only when idle, walks tracks then keyframes
    kti_controller #(
        .MAX_FRAMES (kti_pkg::MAX_FRAMES),
        .TRACKS     (kti_pkg::TRACKS),
        .TW         (TW),
        .IW         (IW),
        .NW         (NW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .frames    (frames),
        .dp_cmd    (dp_cmd),
        .trk       (trk),
        .idx       (idx),
        .comp      (comp)
    );

    // storage and arithmetic: keyframe memory, divider, multiplier, accumulators
    kti_datapath #(
        .MAX_FRAMES (kti_pkg::MAX_FRAMES),
        .TRACKS     (kti_pkg::TRACKS),
        .TW         (TW),
        .IW         (IW),
        .NW         (NW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .trk         (trk),
        .idx         (idx),
        .comp        (comp),
        .track       (track),
        .frame_index (frame_index),
        .frame_count (frame_count),
        .key_time    (key_time),
        .key_x       (key_x),
        .key_y       (key_y),
        .key_angle   (key_angle),
        .eval_time   (eval_time),
        .amount      (amount),
        .dp_status   (dp_status),
        .frames      (frames),
        .out_track   (out_track),
        .out_time    (out_time),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_angle   (out_angle),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> design/kti_datapath.sv
// kti_datapath: keyframe memory, frame counts, divider, shared multiplier,
// accumulators and output register; driven by kti_controller
// depends on kti_pkg
`default_nettype none

module kti_datapath #(
    parameter int MAX_FRAMES = 8,
    parameter int TRACKS     = 4,
    parameter int TW         = 2,
    parameter int IW         = 3,
    parameter int NW         = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kti_pkg::dp_cmd_t   dp_cmd,
    input  wire logic [TW-1:0]      trk,
    input  wire logic [IW-1:0]      idx,
    input  wire logic [1:0]         comp,
    input  wire logic [1:0]         track,
    input  wire logic [2:0]         frame_index,
    input  wire logic [3:0]         frame_count,
    input  wire logic [31:0]        key_time,
    input  wire logic [31:0]        key_x,
    input  wire logic [31:0]        key_y,
    input  wire logic [31:0]        key_angle,
    input  wire logic [31:0]        eval_time,
    input  wire logic [23:0]        amount,
    output kti_pkg::dp_status_t     dp_status,
    output logic [NW-1:0]           frames,
    output logic [1:0]              out_track,
    output logic [31:0]             out_time,
    output logic [31:0]             out_x,
    output logic [31:0]             out_y,
    output logic [31:0]             out_angle,
    output logic                    last
);

    localparam int DEPTH = TRACKS * MAX_FRAMES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    kti_pkg::frame_t mem [DEPTH];
    kti_pkg::frame_t rd_data_reg;
    kti_pkg::frame_t prev_reg;
    kti_pkg::frame_t cur_reg;
    kti_pkg::frame_t res_reg;
    kti_pkg::frame_t acc_reg [TRACKS];
    kti_pkg::frame_t out_reg;
    logic [NW-1:0]   frames_reg [TRACKS];

    logic [31:0]        et_reg;
    logic signed [23:0] amount_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dvs_reg;
    logic               lsb_reg;
    logic [16:0]        quo_reg;
    logic signed [57:0] prod_reg;
    logic [1:0]         out_track_reg;
    logic               last_reg;

    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic               wr_ok;
    logic               cnt_ok;
    logic [NW-1:0]      cnt_sat;
    logic [31:0]        tdiff;
    logic [32:0]        rem_try;
    logic [16:0]        blend;
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] prod_next;
    logic signed [41:0] scaled;
    logic signed [42:0] acc_sum;
    logic [31:0]        acc_sat;
    kti_pkg::frame_t    acc_cur;

    assign wr_ok   = (32'(track) < TRACKS) && (32'(frame_index) < MAX_FRAMES);
    assign cnt_ok  = 32'(track) < TRACKS;
    assign cnt_sat = (32'(frame_count) > MAX_FRAMES) ? NW'(MAX_FRAMES) : NW'(frame_count);
    assign waddr   = AW'(int'(track) * MAX_FRAMES + int'(frame_index));
    assign raddr   = AW'(int'(trk) * MAX_FRAMES + int'(idx));
    assign frames  = frames_reg[trk];
    assign acc_cur = acc_reg[trk];

    assign dp_status.hit = (prev_reg[kti_pkg::COMP_TIME] <= et_reg)
                        && (et_reg <= cur_reg[kti_pkg::COMP_TIME]);

    // restoring divider, one quotient bit a cycle
    assign tdiff   = et_reg - prev_reg[kti_pkg::COMP_TIME];
    assign rem_try = {rem_reg, dp_cmd.div_first ? lsb_reg : 1'b0};
    assign blend   = (dvs_reg == 32'd0) ? 17'd0 : quo_reg;

    // shared multiplier: lerp slope times blend, or value times amount
    always_comb
    begin
        if (dp_cmd.add_mul)
        begin
            mul_a = $signed({res_reg[comp][31], res_reg[comp]});
            mul_b = 25'(amount_reg);
        end
        else
        begin
            mul_a = $signed({cur_reg[comp][31], cur_reg[comp]})
                  - $signed({prev_reg[comp][31], prev_reg[comp]});
            mul_b = $signed({8'd0, blend});
        end
        prod_next = 58'(mul_a) * 58'(mul_b);
    end

    assign scaled  = prod_reg[57:16];
    assign acc_sum = 43'($signed(acc_cur[comp])) + 43'(scaled);

    always_comb
    begin
        if (acc_sum > 43'sd2147483647)
            acc_sat = 32'h7fff_ffff;
        else if (acc_sum < -43'sd2147483648)
            acc_sat = 32'h8000_0000;
        else
            acc_sat = acc_sum[31:0];
    end

    // keyframe store, read data registered
    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_key && wr_ok)
            mem[waddr] <= {key_angle, key_y, key_x, key_time};
        if (dp_cmd.rd_issue)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch_eval)
        begin
            et_reg     <= eval_time;
            amount_reg <= $signed(amount);
        end
        if (dp_cmd.shift_frame)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_data_reg;
        end
        if (dp_cmd.div_init)
        begin
            rem_reg <= {1'b0, tdiff[31:1]};
            lsb_reg <= tdiff[0];
            dvs_reg <= cur_reg[kti_pkg::COMP_TIME] - prev_reg[kti_pkg::COMP_TIME];
            quo_reg <= '0;
        end
        else if (dp_cmd.div_step)
        begin
            if (rem_try >= {1'b0, dvs_reg})
            begin
                rem_reg <= 32'(rem_try - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try[31:0];
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
        end
        if (dp_cmd.lerp_mul || dp_cmd.add_mul)
            prod_reg <= prod_next;
        if (dp_cmd.clr_res)
            res_reg <= '0;
        else if (dp_cmd.take_cur)
            res_reg <= cur_reg;
        else if (dp_cmd.div_init)
            res_reg[kti_pkg::COMP_TIME] <= et_reg;
        else if (dp_cmd.lerp_add)
            res_reg[comp] <= prev_reg[comp] + prod_reg[47:16];
        if (dp_cmd.out_load)
        begin
            out_reg       <= acc_cur;
            out_track_reg <= 2'(trk);
            last_reg      <= dp_cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TRACKS; t++)
            begin
                frames_reg[t] <= '0;
                acc_reg[t]    <= '0;
            end
        end
        else
        begin
            if (dp_cmd.wr_count && cnt_ok)
                frames_reg[track[TW-1:0]] <= cnt_sat;
            if (dp_cmd.set_acc)
                acc_reg[trk] <= res_reg;
            else if (dp_cmd.add_acc)
                acc_reg[trk][comp] <= acc_sat;
        end
    end

    assign out_track = out_track_reg;
    assign out_time  = out_reg[kti_pkg::COMP_TIME];
    assign out_x     = out_reg[kti_pkg::COMP_X];
    assign out_y     = out_reg[kti_pkg::COMP_Y];
    assign out_angle = out_reg[kti_pkg::COMP_ANGLE];
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> design/kti_controller.sv
// kti_controller: sequencer for load, count and evaluate commands
// walks tracks and keyframes and issues datapath commands; depends on kti_pkg
`default_nettype none

module kti_controller #(
    parameter int MAX_FRAMES = 8,
    parameter int TRACKS     = 4,
    parameter int TW         = 2,
    parameter int IW         = 3,
    parameter int NW         = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          cmd,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire kti_pkg::dp_status_t dp_status,
    input  wire logic [NW-1:0]       frames,
    output kti_pkg::dp_cmd_t         dp_cmd,
    output logic [TW-1:0]            trk,
    output logic [IW-1:0]            idx,
    output logic [1:0]               comp
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_START = 12'b0000_0000_0010,
        S_READ  = 12'b0000_0000_0100,
        S_LATCH = 12'b0000_0000_1000,
        S_CHECK = 12'b0000_0001_0000,
        S_DIV   = 12'b0000_0010_0000,
        S_MUL   = 12'b0000_0100_0000,
        S_LERP  = 12'b0000_1000_0000,
        S_ACC   = 12'b0001_0000_0000,
        S_AMUL  = 12'b0010_0000_0000,
        S_AADD  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [TW-1:0] trk_reg, trk_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]    comp_reg, comp_next;
    logic [4:0]    div_reg, div_next;
    logic          add_mode_reg, add_mode_next;
    logic          out_valid_reg;
    logic          accept;
    logic          out_free;
    logic          trk_last;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign trk_last = (trk_reg == TW'(TRACKS - 1));

    always_comb
    begin
        state_next    = state_reg;
        trk_next      = trk_reg;
        idx_next      = idx_reg;
        comp_next     = comp_reg;
        div_next      = div_reg;
        add_mode_next = add_mode_reg;
        dp_cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kti_pkg::cmd_code_t'(cmd))
                        kti_pkg::CMD_LOAD_KEY:  dp_cmd.wr_key = 1'b1;
                        kti_pkg::CMD_SET_COUNT: dp_cmd.wr_count = 1'b1;
                        kti_pkg::CMD_EVAL_SET,
                        kti_pkg::CMD_EVAL_ADD:
                        begin
                            dp_cmd.latch_eval = 1'b1;
                            add_mode_next     = (cmd == kti_pkg::CMD_EVAL_ADD);
                            trk_next          = '0;
                            state_next        = S_START;
                        end
                        default: ;
                    endcase
                end
            end
            S_START:
            begin
                if (frames == '0)
                begin
                    dp_cmd.clr_res = 1'b1;
                    state_next     = S_ACC;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                dp_cmd.rd_issue = 1'b1;
                state_next      = S_LATCH;
            end
            S_LATCH:
            begin
                dp_cmd.shift_frame = 1'b1;
                state_next         = S_CHECK;
            end
            S_CHECK:
            begin
                if (idx_reg == '0)
                begin
                    if (frames == NW'(1))
                    begin
                        dp_cmd.take_cur = 1'b1;
                        state_next      = S_ACC;
                    end
                    else
                    begin
                        idx_next   = IW'(1);
                        state_next = S_READ;
                    end
                end
                else if (dp_status.hit)
                begin
                    dp_cmd.div_init = 1'b1;
                    div_next        = '0;
                    state_next      = S_DIV;
                end
                else if (NW'(idx_reg) == frames - NW'(1))
                begin
                    dp_cmd.take_cur = 1'b1;
                    state_next      = S_ACC;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_READ;
                end
            end
            S_DIV:
            begin
                dp_cmd.div_step  = 1'b1;
                dp_cmd.div_first = (div_reg == '0);
                div_next         = div_reg + 5'd1;
                if (div_reg == 5'd16)
                begin
                    comp_next  = kti_pkg::COMP_X;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                dp_cmd.lerp_mul = 1'b1;
                state_next      = S_LERP;
            end
            S_LERP:
            begin
                dp_cmd.lerp_add = 1'b1;
                if (comp_reg == kti_pkg::COMP_ANGLE)
                    state_next = S_ACC;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_ACC:
            begin
                if (add_mode_reg)
                begin
                    comp_next  = kti_pkg::COMP_X;
                    state_next = S_AMUL;
                end
                else
                begin
                    dp_cmd.set_acc = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_AMUL:
            begin
                dp_cmd.add_mul = 1'b1;
                state_next     = S_AADD;
            end
            S_AADD:
            begin
                dp_cmd.add_acc = 1'b1;
                if (comp_reg == kti_pkg::COMP_ANGLE)
                    state_next = S_OUT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_AMUL;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    dp_cmd.out_last = trk_last;
                    if (trk_last)
                        state_next = S_IDLE;
                    else
                    begin
                        trk_next   = trk_reg + TW'(1);
                        state_next = S_START;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            trk_reg       <= '0;
            idx_reg       <= '0;
            comp_reg      <= '0;
            div_reg       <= '0;
            add_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            trk_reg      <= trk_next;
            idx_reg      <= idx_next;
            comp_reg     <= comp_next;
            div_reg      <= div_next;
            add_mode_reg <= add_mode_next;
            if (dp_cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign trk       = trk_reg;
    assign idx       = idx_reg;
    assign comp      = comp_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (NW'(idx_reg) < frames))
        else $error("frame index beyond frame count");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_reg == 5'd16) |=> (state_reg == S_MUL))
        else $error("divider did not finish after 17 steps");

endmodule

`default_nettype wire
